FILE: design/first_fit_heap_allocator_macros.svh
// Assertion macros for the first-fit heap allocator.
`ifndef FIRST_FIT_HEAP_ALLOCATOR_MACROS_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_MACROS_SVH
`ifndef SYNTHESIS
`define FFHA_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define FFHA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define FFHA_ASSERT(lbl, clk, rst, prop, msg)
`define FFHA_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

FILE: design/ffha_pkg.sv
package ffha_pkg;

   localparam int HEAP_BYTES_DEF   = 4096;
   localparam int HEADER_BYTES_DEF = 16;
   localparam int MAX_SEGMENTS_DEF = 256;

   localparam logic [2:0] ST_ALLOCATED = 3'd0;
   localparam logic [2:0] ST_NO_FIT    = 3'd1;
   localparam logic [2:0] ST_FREED     = 3'd2;
   localparam logic [2:0] ST_NOT_FOUND = 3'd3;
   localparam logic [2:0] ST_EXHAUSTED = 3'd4;

   localparam logic KIND_ALLOC = 1'b0;
   localparam logic KIND_FREE  = 1'b1;

   typedef struct packed {
      logic        kind;
      logic [11:0] request_bytes;
      logic [15:0] block_id;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [15:0] granted_id;
      logic [11:0] block_offset;
      logic [11:0] block_bytes;
      logic [1:0]  merged_count;
   } rsp_type;

   typedef enum logic [4:0] {
      S_INIT, S_IDLE,
      S_A_RD, S_A_CK,
      S_F_DEC, S_F_RD, S_F_CK,
      S_S_RD, S_S_CK, S_DECIDE,
      S_M_RD, S_M_CK,
      S_R_RD, S_R_CK,
      S_LO,
      S_P_DEC, S_P_RD, S_P_CK, S_PUT
   } state_type;

endpackage

FILE: design/first_fit_heap_allocator.sv
// Allocate walks the free segments in order and takes the first that fits, else reports no fit.
// Free searches the allocated blocks from the newest, scans every free segment for neighbours,
// shifts the allocated tail (and the free tail after an upper merge) down one place, and on a
// push to the front moves every free entry up one place.
// One item at a time; busy is high from acceptance and drops in the strobe cycle. Sync reset;
// the init state writes the first free segment. The receiver cannot stall results.
`include "first_fit_heap_allocator_macros.svh"
module first_fit_heap_allocator #(
   parameter int HEAP_BYTES   = ffha_pkg::HEAP_BYTES_DEF,
   parameter int HEADER_BYTES = ffha_pkg::HEADER_BYTES_DEF,
   parameter int MAX_SEGMENTS = ffha_pkg::MAX_SEGMENTS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  ffha_pkg::req_type req_data,
   output logic              rsp_strobe,
   output ffha_pkg::rsp_type rsp_data
);
   import ffha_pkg::*;

   localparam int HB = $clog2(HEAP_BYTES) + 1;
   localparam int AW = (HB > 13) ? HB : 13;
   localparam int IW = $clog2(MAX_SEGMENTS);
   localparam int CW = $clog2(MAX_SEGMENTS + 1);
   localparam logic [AW-1:0] HDR = AW'(HEADER_BYTES);
   localparam logic [CW-1:0] MAXC = CW'(MAX_SEGMENTS);

   typedef struct packed {
      logic [AW-1:0] off;
      logic [AW-1:0] size;
   } seg_type;

   typedef struct packed {
      logic [AW-1:0] off;
      logic [AW-1:0] size;
      logic [15:0]   id;
   } blk_type;

   seg_type fs_mem [MAX_SEGMENTS];
   blk_type ab_mem [MAX_SEGMENTS];
   seg_type fs_q;
   blk_type ab_q;

   state_type     state_ff, state_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic [CW-1:0] fcnt_ff, fcnt_in, acnt_ff, acnt_in, k_ff, k_in;
   logic [CW-1:0] up_ff, up_in, lo_ff, lo_in;
   logic [15:0]   idc_ff, idc_in;
   req_type       req_ff, req_in;
   logic [AW-1:0] start_ff, start_in, size_ff, size_in;
   logic [AW-1:0] upsz_ff, upsz_in, loff_ff, loff_in, losz_ff, losz_in;
   logic [AW-1:0] segsz_ff, segsz_in;
   logic          hup_ff, hup_in, hlo_ff, hlo_in;
   logic [1:0]    mrg_ff, mrg_in;
   logic          strobe_ff, strobe_in;
   rsp_type       rsp_ff, rsp_in;

   logic          fs_we, ab_we;
   logic [IW-1:0] fs_wa, ab_wa;
   seg_type       fs_wd;
   blk_type       ab_wd;
   logic [AW-1:0] total, end_addr;

   assign total    = AW'(req_ff.request_bytes) + HDR;
   assign end_addr = start_ff + HDR + size_ff;

   always_ff @(posedge clock) begin
      if (fs_we) fs_mem[fs_wa] <= fs_wd;
      if (ab_we) ab_mem[ab_wa] <= ab_wd;
      fs_q <= fs_mem[idx_ff[IW-1:0]];
      ab_q <= ab_mem[idx_ff[IW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_INIT;
         fcnt_ff   <= CW'(1);
         acnt_ff   <= '0;
         idc_ff    <= '0;
         strobe_ff <= 1'b0;
         idx_ff    <= '0;
      end else begin
         state_ff  <= state_in;
         fcnt_ff   <= fcnt_in;
         acnt_ff   <= acnt_in;
         idc_ff    <= idc_in;
         strobe_ff <= strobe_in;
         idx_ff    <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff   <= req_in;
      k_ff     <= k_in;
      up_ff    <= up_in;
      lo_ff    <= lo_in;
      start_ff <= start_in;
      size_ff  <= size_in;
      upsz_ff  <= upsz_in;
      loff_ff  <= loff_in;
      losz_ff  <= losz_in;
      segsz_ff <= segsz_in;
      hup_ff   <= hup_in;
      hlo_ff   <= hlo_in;
      mrg_ff   <= mrg_in;
      rsp_ff   <= rsp_in;
   end

   always_comb begin
      state_in  = state_ff;
      idx_in    = idx_ff;
      fcnt_in   = fcnt_ff;
      acnt_in   = acnt_ff;
      idc_in    = idc_ff;
      req_in    = req_ff;
      k_in      = k_ff;
      up_in     = up_ff;
      lo_in     = lo_ff;
      start_in  = start_ff;
      size_in   = size_ff;
      upsz_in   = upsz_ff;
      loff_in   = loff_ff;
      losz_in   = losz_ff;
      segsz_in  = segsz_ff;
      hup_in    = hup_ff;
      hlo_in    = hlo_ff;
      mrg_in    = mrg_ff;
      strobe_in = 1'b0;
      rsp_in    = rsp_ff;
      fs_we     = 1'b0;
      fs_wa     = idx_ff[IW-1:0];
      fs_wd     = fs_q;
      ab_we     = 1'b0;
      ab_wa     = acnt_ff[IW-1:0];
      ab_wd     = ab_q;

      case (state_ff)
         S_INIT: begin
            fs_we    = 1'b1;
            fs_wa    = '0;
            fs_wd    = '{off: '0, size: AW'(HEAP_BYTES) - HDR};
            state_in = S_IDLE;
         end
         S_IDLE: begin
            if (start) begin
               req_in = req_data;
               if (req_data.kind == KIND_ALLOC) begin
                  idx_in   = '0;
                  state_in = S_A_RD;
               end else begin
                  idx_in   = acnt_ff;
                  state_in = S_F_DEC;
               end
            end
         end
         S_A_RD: begin
            if (idx_ff >= fcnt_ff) begin
               rsp_in    = '{status: ST_NO_FIT, default: '0};
               strobe_in = 1'b1;
               state_in  = S_IDLE;
            end else begin
               state_in = S_A_CK;
            end
         end
         S_A_CK: begin
            if (fs_q.size >= total) begin
               state_in  = S_IDLE;
               strobe_in = 1'b1;
               if (acnt_ff >= MAXC) begin
                  rsp_in = '{status: ST_NO_FIT, default: '0};
               end else if (idc_ff == 16'hFFFF) begin
                  rsp_in = '{status: ST_EXHAUSTED, default: '0};
               end else begin
                  fs_we   = 1'b1;
                  fs_wd   = '{off: fs_q.off + total, size: fs_q.size - total};
                  ab_we   = 1'b1;
                  ab_wd   = '{off: fs_q.off, size: AW'(req_ff.request_bytes),
                              id: idc_ff + 16'd1};
                  idc_in  = idc_ff + 16'd1;
                  acnt_in = acnt_ff + CW'(1);
                  rsp_in  = '{status: ST_ALLOCATED, granted_id: idc_ff + 16'd1,
                              block_offset: fs_q.off[11:0],
                              block_bytes: req_ff.request_bytes, merged_count: 2'd0};
               end
            end else begin
               idx_in   = idx_ff + CW'(1);
               state_in = S_A_RD;
            end
         end
         S_F_DEC: begin
            if (idx_ff == '0) begin
               rsp_in    = '{status: ST_NOT_FOUND, default: '0};
               strobe_in = 1'b1;
               state_in  = S_IDLE;
            end else begin
               idx_in   = idx_ff - CW'(1);
               state_in = S_F_RD;
            end
         end
         S_F_RD: state_in = S_F_CK;
         S_F_CK: begin
            if (ab_q.id == req_ff.block_id) begin
               k_in     = idx_ff;
               start_in = ab_q.off;
               size_in  = ab_q.size;
               hup_in   = 1'b0;
               hlo_in   = 1'b0;
               idx_in   = '0;
               state_in = S_S_RD;
            end else begin
               state_in = S_F_DEC;
            end
         end
         S_S_RD: state_in = (idx_ff >= fcnt_ff) ? S_DECIDE : S_S_CK;
         S_S_CK: begin
            if (!hup_ff && fs_q.off == end_addr) begin
               hup_in  = 1'b1;
               up_in   = idx_ff;
               upsz_in = fs_q.size;
            end
            if (!hlo_ff && fs_q.off + HDR + fs_q.size == start_ff) begin
               hlo_in  = 1'b1;
               lo_in   = idx_ff;
               loff_in = fs_q.off;
               losz_in = fs_q.size;
            end
            idx_in   = idx_ff + CW'(1);
            state_in = S_S_RD;
         end
         S_DECIDE: begin
            if (!hup_ff && !hlo_ff && fcnt_ff >= MAXC) begin
               rsp_in    = '{status: ST_NOT_FOUND, default: '0};
               strobe_in = 1'b1;
               state_in  = S_IDLE;
            end else begin
               idx_in   = k_ff + CW'(1);
               state_in = S_M_RD;
            end
         end
         S_M_RD: begin
            if (idx_ff >= acnt_ff) begin
               acnt_in  = acnt_ff - CW'(1);
               segsz_in = size_ff;
               mrg_in   = 2'd1;
               if (hup_ff) begin
                  segsz_in = size_ff + upsz_ff + HDR;
                  mrg_in   = 2'd2;
                  idx_in   = up_ff + CW'(1);
                  state_in = S_R_RD;
               end else begin
                  state_in = S_LO;
               end
            end else begin
               state_in = S_M_CK;
            end
         end
         S_M_CK: begin
            ab_we    = 1'b1;
            ab_wa    = IW'(idx_ff - CW'(1));
            ab_wd    = ab_q;
            idx_in   = idx_ff + CW'(1);
            state_in = S_M_RD;
         end
         S_R_RD: begin
            if (idx_ff >= fcnt_ff) begin
               fcnt_in = fcnt_ff - CW'(1);
               if (hlo_ff && lo_ff > up_ff) lo_in = lo_ff - CW'(1);
               state_in = S_LO;
            end else begin
               state_in = S_R_CK;
            end
         end
         S_R_CK: begin
            fs_we    = 1'b1;
            fs_wa    = IW'(idx_ff - CW'(1));
            fs_wd    = fs_q;
            idx_in   = idx_ff + CW'(1);
            state_in = S_R_RD;
         end
         S_LO: begin
            if (hlo_ff) begin
               fs_we     = 1'b1;
               fs_wa     = lo_ff[IW-1:0];
               fs_wd     = '{off: loff_ff, size: losz_ff + segsz_ff + HDR};
               rsp_in    = '{status: ST_FREED, granted_id: req_ff.block_id,
                             block_offset: start_ff[11:0], block_bytes: size_ff[11:0],
                             merged_count: mrg_ff + 2'd1};
               strobe_in = 1'b1;
               state_in  = S_IDLE;
            end else begin
               idx_in   = fcnt_ff;
               state_in = S_P_DEC;
            end
         end
         S_P_DEC: begin
            if (idx_ff == '0) begin
               state_in = S_PUT;
            end else begin
               idx_in   = idx_ff - CW'(1);
               state_in = S_P_RD;
            end
         end
         S_P_RD: state_in = S_P_CK;
         S_P_CK: begin
            fs_we    = 1'b1;
            fs_wa    = IW'(idx_ff + CW'(1));
            fs_wd    = fs_q;
            state_in = S_P_DEC;
         end
         S_PUT: begin
            fs_we     = 1'b1;
            fs_wa     = '0;
            fs_wd     = '{off: start_ff, size: segsz_ff};
            fcnt_in   = fcnt_ff + CW'(1);
            rsp_in    = '{status: ST_FREED, granted_id: req_ff.block_id,
                          block_offset: start_ff[11:0], block_bytes: size_ff[11:0],
                          merged_count: mrg_ff};
            strobe_in = 1'b1;
            state_in  = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = strobe_ff;
   assign rsp_data   = rsp_ff;

   `FFHA_ASSERT(a_accept_busy, clock, reset, start && !busy |=> busy, "accept did not raise busy")
   `FFHA_ASSERT(a_strobe_pulse, clock, reset, rsp_strobe |=> !rsp_strobe, "strobe longer than one cycle")
   `FFHA_ASSERT(a_strobe_idle, clock, reset, rsp_strobe |-> !busy, "result while still busy")
   `FFHA_ASSERT(a_fcnt_nonzero, clock, reset, fcnt_ff != '0 && fcnt_ff <= MAXC, "free count out of range")
   `FFHA_ASSERT(a_acnt_range, clock, reset, acnt_ff <= MAXC, "allocated count above table size")
   `FFHA_ASSERT_ALWAYS(a_reset_quiet, clock, reset |=> !rsp_strobe, "strobe right after reset")
endmodule

FILE: verif/tb.sv
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import ffha_pkg::*;

   localparam int HEAP  = 4096;
   localparam int HDR   = 16;
   localparam int MAXS  = 256;
   localparam int WATCHDOG = 200000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_data = '0;
   logic    rsp_strobe;
   rsp_type rsp_data;

   first_fit_heap_allocator u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_strobe(rsp_strobe), .rsp_data(rsp_data)
   );

   always #5 clock = ~clock;

   // shadow heap state
   int unsigned seg_off[$], seg_size[$];
   int unsigned blk_off[$], blk_size[$], blk_id[$];
   int unsigned next_id;
   rsp_type     pending_rsp[$];
   int          errors = 0;
   int          idle_cycles = 0;

   function automatic rsp_type heap_step(req_type r);
      rsp_type o = '0;
      int unsigned total, i, k, st, sz, e, seg_sz, up, lo, merged;
      bit fit, found, has_up, has_lo;
      fit = 0; found = 0; has_up = 0; has_lo = 0; up = 0; lo = 0; merged = 1;
      if (r.kind == KIND_ALLOC) begin
         total = r.request_bytes + HDR;
         for (i = 0; i < seg_off.size(); i++)
            if (seg_size[i] >= total) begin
               fit = 1;
               break;
            end
         if (!fit || blk_id.size() >= MAXS) begin
            o.status = ST_NO_FIT;
            return o;
         end
         if (next_id >= 16'hFFFF) begin
            o.status = ST_EXHAUSTED;
            return o;
         end
         next_id++;
         blk_off.push_back(seg_off[i]);
         blk_size.push_back(32'(r.request_bytes));
         blk_id.push_back(next_id);
         o.status = ST_ALLOCATED;
         o.granted_id = next_id[15:0];
         o.block_offset = seg_off[i][11:0];
         o.block_bytes = r.request_bytes;
         seg_off[i] += total;
         seg_size[i] -= total;
         return o;
      end
      for (k = blk_id.size(); k > 0; k--)
         if (blk_id[k-1] == r.block_id) begin
            found = 1;
            break;
         end
      if (!found) begin
         o.status = ST_NOT_FOUND;
         return o;
      end
      k--;
      st = blk_off[k];
      sz = blk_size[k];
      e = st + HDR + sz;
      for (i = 0; i < seg_off.size(); i++) begin
         if (!has_up && seg_off[i] == e) begin
            has_up = 1;
            up = i;
         end
         if (!has_lo && seg_off[i] + HDR + seg_size[i] == st) begin
            has_lo = 1;
            lo = i;
         end
      end
      if (!has_up && !has_lo && seg_off.size() >= MAXS) begin
         o.status = ST_NOT_FOUND;
         return o;
      end
      blk_off.delete(k);
      blk_size.delete(k);
      blk_id.delete(k);
      seg_sz = sz;
      if (has_up) begin
         seg_sz += seg_size[up] + HDR;
         seg_off.delete(up);
         seg_size.delete(up);
         if (has_lo && lo > up) lo--;
         merged++;
      end
      if (has_lo) begin
         seg_size[lo] += seg_sz + HDR;
         merged++;
      end else begin
         seg_off.push_front(st);
         seg_size.push_front(seg_sz);
      end
      o.status = ST_FREED;
      o.granted_id = r.block_id;
      o.block_offset = st[11:0];
      o.block_bytes = sz[11:0];
      o.merged_count = merged[1:0];
      return o;
   endfunction

   // directed table: fixed expectation where obvious, else predictor
   typedef struct {
      req_type     beat;
      bit          fixed;
      rsp_type     want;
   } row_type;

   function automatic req_type mk(logic k, int unsigned b, int unsigned id);
      req_type r;
      r.kind = k;
      r.request_bytes = b[11:0];
      r.block_id = id[15:0];
      return r;
   endfunction

   function automatic rsp_type fail_rsp(logic [2:0] s);
      rsp_type o = '0;
      o.status = s;
      return o;
   endfunction

   task automatic send(req_type r, bit fixed, rsp_type want);
      rsp_type p;
      p = heap_step(r);
      if (fixed && p !== want)
         $display("%0t table row disagrees: expected %p, predicted %p", $time, want, p);
      start <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (busy) @(posedge clock);
      pending_rsp.push_back(fixed ? want : p);
      start <= 1'b0;
      @(posedge clock);
   endtask

   task automatic gap();
      int n;
      if ($urandom_range(0, 2) == 0) return;
      n = ($urandom_range(0, 15) == 0) ? $urandom_range(10, 60) : $urandom_range(1, 3);
      repeat (n) @(posedge clock);
   endtask

   task automatic drain();
      while (pending_rsp.size() != 0) @(posedge clock);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         idle_cycles <= 0;
      end else begin
         if (rsp_strobe) begin
            if (pending_rsp.size() == 0) begin
               $display("%0t unexpected result: expected none, actual %p", $time, rsp_data);
               errors++;
            end else begin
               rsp_type w;
               w = pending_rsp.pop_front();
               if (rsp_data.status !== w.status || rsp_data.granted_id !== w.granted_id ||
                   rsp_data.block_offset !== w.block_offset ||
                   rsp_data.block_bytes !== w.block_bytes ||
                   rsp_data.merged_count !== w.merged_count) begin
                  $display("%0t mismatch: expected %p, actual %p", $time, w, rsp_data);
                  errors++;
               end
            end
         end
         if (rsp_strobe || (start && !busy)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG) begin
            $display("FAIL first_fit_heap_allocator");
            $finish;
         end
      end
   end

   initial begin
      row_type rows[$];
      rsp_type a;
      int unsigned pick;
      seg_off = {0};
      seg_size = {HEAP - HDR};
      next_id = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      a = '0;
      rows.push_back('{mk(KIND_FREE, 0, 0), 1, fail_rsp(ST_NOT_FOUND)});
      rows.push_back('{mk(KIND_FREE, 4095, 16'hFFFF), 1, fail_rsp(ST_NOT_FOUND)});
      rows.push_back('{mk(KIND_ALLOC, 4095, 0), 1, fail_rsp(ST_NO_FIT)});
      a.status = ST_ALLOCATED; a.granted_id = 1; a.block_bytes = 0;
      rows.push_back('{mk(KIND_ALLOC, 0, 16'hFFFF), 1, a});
      rows.push_back('{mk(KIND_ALLOC, 100, 0), 0, a});
      rows.push_back('{mk(KIND_ALLOC, 200, 0), 0, a});
      rows.push_back('{mk(KIND_ALLOC, 50, 0), 0, a});
      rows.push_back('{mk(KIND_FREE, 0, 2), 0, a});
      rows.push_back('{mk(KIND_FREE, 0, 2), 1, fail_rsp(ST_NOT_FOUND)});
      rows.push_back('{mk(KIND_FREE, 0, 3), 0, a});
      rows.push_back('{mk(KIND_FREE, 0, 1), 0, a});
      rows.push_back('{mk(KIND_ALLOC, 4080, 0), 1, fail_rsp(ST_NO_FIT)});
      rows.push_back('{mk(KIND_ALLOC, 4064, 0), 0, a});
      rows.push_back('{mk(KIND_ALLOC, 0, 0), 0, a});
      rows.push_back('{mk(KIND_FREE, 0, 5), 0, a});
      rows.push_back('{mk(KIND_ALLOC, 2000, 0), 0, a});
      rows.push_back('{mk(KIND_ALLOC, 2000, 0), 0, a});
      rows.push_back('{mk(KIND_FREE, 0, 6), 0, a});
      rows.push_back('{mk(KIND_FREE, 0, 7), 0, a});
      foreach (rows[i]) begin
         send(rows[i].beat, rows[i].fixed, rows[i].want);
         gap();
      end
      drain();

      // fill toward table limits with tiny blocks, then punch holes
      for (int i = 0; i < 260; i++) begin
         send(mk(KIND_ALLOC, $urandom_range(0, 1), $urandom), 0, a);
         if (i % 64 == 0) gap();
      end
      for (int i = 0; i < 100; i++) begin
         pick = (blk_id.size() != 0) ? blk_id[$urandom_range(0, blk_id.size() - 1)]
                                     : $urandom;
         send(mk(KIND_FREE, $urandom, pick), 0, a);
         if (i % 50 == 0) gap();
      end
      drain();
      repeat ($urandom_range(20, 80)) @(posedge clock);

      // mixed random traffic
      for (int i = 0; i < 200; i++) begin
         if ($urandom_range(0, 1) == 0) begin
            case ($urandom_range(0, 3))
               0: pick = $urandom_range(0, 4095);
               1: pick = $urandom_range(0, 31);
               default: pick = $urandom_range(0, 300);
            endcase
            send(mk(KIND_ALLOC, pick, $urandom), 0, a);
         end else begin
            if (blk_id.size() != 0 && $urandom_range(0, 7) != 0)
               pick = blk_id[$urandom_range(0, blk_id.size() - 1)];
            else
               pick = $urandom_range(0, 65535);
            send(mk(KIND_FREE, $urandom, pick), 0, a);
         end
         if ($urandom_range(0, 3) != 0) gap();
      end

      drain();
      repeat (50) @(posedge clock);
      if (errors == 0)
         $display("PASS first_fit_heap_allocator");
      else
         $display("FAIL first_fit_heap_allocator");
      $finish;
   end
endmodule

FILE: files.f
+incdir+design
design/ffha_pkg.sv
design/first_fit_heap_allocator.sv
verif/tb.sv
